[src/vpdb_pkg.sv]
// Shared types and constants for the voxel point density binning block.
// No dependencies; imported by vpdb_axis and voxel_point_density_binning.
package vpdb_pkg;

	localparam int COORD_W = 32;
	localparam int CNT_W   = 32;
	localparam int DENS_W  = 48;
	localparam int SEL_W   = 15;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [DENS_W-1:0] DENS_MAX = '1;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_Y     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_Z     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIMS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_VOL   = 3'd7;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_sel_t;

	typedef struct packed {
		logic      valid;
		axis_sel_t axis;
	} axis_tag_t;

	typedef struct packed {
		logic      valid;
		axis_sel_t axis;
		logic      clamp;
	} axis_stat_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_AXIS,
		ST_WAIT,
		ST_LIN1,
		ST_LIN2,
		ST_MOD,
		ST_MEM_RD,
		ST_MEM_WR,
		ST_DENS
	} state_t;

endpackage

[src/vpdb_axis.sv]
// Three-stage axis unit: offset from origin, scale by reciprocal cell width, clamp.
// Depends on vpdb_pkg.
module vpdb_axis #(
	parameter int GRID_MAX = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vpdb_pkg::axis_tag_t           tag,
	input  logic [31:0]                   point,
	input  logic [31:0]                   origin,
	input  logic [31:0]                   inv,
	input  logic [$clog2(GRID_MAX+1)-1:0] dim,
	output logic [$clog2(GRID_MAX)-1:0]   idx,
	output vpdb_pkg::axis_stat_t          stat
);
	import vpdb_pkg::*;

	localparam int DIM_W = $clog2(GRID_MAX + 1);
	localparam int IDX_W = $clog2(GRID_MAX);

	axis_tag_t          tag_s1, tag_s2;
	logic [32:0]        off_s1;
	logic [31:0]        inv_s1;
	logic [DIM_W-1:0]   dim_s1, dim_s2;
	logic               neg_s2, inv_nz_s2;
	logic [31:0]        q_s2;
	logic [63:0]        prod_c;
	logic [IDX_W-1:0]   idx_c;
	logic               clamp_c;

	assign prod_c = 64'(off_s1[31:0]) * 64'(inv_s1);

	always_comb begin
		if (neg_s2) begin
			idx_c   = '0;
			clamp_c = inv_nz_s2;
		end else if (q_s2 >= 32'(dim_s2)) begin
			idx_c   = IDX_W'(dim_s2 - DIM_W'(1));
			clamp_c = 1'b1;
		end else begin
			idx_c   = IDX_W'(q_s2);
			clamp_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			stat   <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			stat   <= '{valid: tag_s2.valid, axis: tag_s2.axis, clamp: clamp_c};
		end
	end

	always_ff @(posedge clk) begin
		off_s1    <= {point[31], point} - {origin[31], origin};
		inv_s1    <= inv;
		dim_s1    <= dim;
		neg_s2    <= off_s1[32];
		inv_nz_s2 <= |inv_s1;
		q_s2      <= prod_c[63:32];
		dim_s2    <= dim_s1;
		idx       <= idx_c;
	end

endmodule

[src/voxel_point_density_binning.sv]
// Voxel point density binning: adds points into a voxel count grid, reads and clears cells.
// Depends on vpdb_pkg and vpdb_axis.
//
// After reset the count memory is cleared one entry per cycle, during which no item is
// accepted. Items are processed one at a time by a sequencer around a single-port count
// memory with a registered read. A read item goes through memory read, write-back and
// result load before the next acceptance. An add item issues its three axes in turn to the
// shared axis unit and its three-stage pipeline, forms the linear index (ST_LIN1, ST_LIN2),
// then does the memory read, write-back and density multiply. When the linear index is at
// or beyond TABLE_DEPTH, a reciprocal multiply and a subtract first form the address as its
// remainder by TABLE_DEPTH. The result register lets the sequencer accept the next item
// while a result waits; a stalled result holds the sequencer only in its last step.
module voxel_point_density_binning #(
	parameter int GRID_MAX    = 32,
	parameter int TABLE_DEPTH = 32768
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,   // point_x, point_y, point_z, cell_select, pad
	input  logic [0:0]   s_axis_tuser,   // opcode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,   // cell_index, cell_count, density, clamped
	output logic [0:0]   m_axis_tuser    // kind
);
	import vpdb_pkg::*;

	localparam int DIM_W  = $clog2(GRID_MAX + 1);
	localparam int IDX_W  = $clog2(GRID_MAX);
	localparam int DXY_W  = 2 * DIM_W;
	localparam int LIN_W  = 3 * IDX_W;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int MOD_SH = LIN_W + ADDR_W;
	localparam logic [63:0] RECIP =
		((64'd1 << MOD_SH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
	localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(TABLE_DEPTH - 1);

	function automatic logic [DIM_W-1:0] dim_of(input logic [7:0] f);
		logic [DIM_W-1:0] d;
		if (f == 8'd0)
			d = DIM_W'(1);
		else if (32'(f) > 32'(GRID_MAX))
			d = DIM_W'(GRID_MAX);
		else
			d = DIM_W'(f);
		return d;
	endfunction

	state_t state_q, state_d;

	logic [31:0] min_x_q, min_y_q, min_z_q;
	logic [31:0] inv_x_q, inv_y_q, inv_z_q;
	logic [23:0] dims_q;
	logic [31:0] inv_vol_q;

	logic [DIM_W-1:0] dx_q, dy_q, dz_q;
	logic [DXY_W-1:0] dxy_q;

	logic              op_q;
	logic [31:0]       px_q, py_q, pz_q;
	axis_sel_t         axis_q;
	logic [IDX_W-1:0]  ix_q, iy_q, iz_q;
	logic              clamp_q;
	logic [LIN_W-1:0]  t1_q, t2_q, lin_q;
	logic [LIN_W-1:0]  quo_q;
	logic              mod_ph_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SEL_W-1:0]  cidx_q;
	logic              in_range_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] clr_q;

	logic              out_valid_q;
	logic              out_kind_q;
	logic [SEL_W-1:0]  out_cidx_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [DENS_W-1:0] out_dens_q;
	logic              out_clamp_q;

	logic [CNT_W-1:0]  count_mem [TABLE_DEPTH];
	logic [CNT_W-1:0]  rdata_q;

	logic              accept;
	logic              mem_we, mem_re, out_load;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CNT_W-1:0]  mem_wdata;

	logic [LIN_W-1:0]  lin_c;
	logic              lin_wrap;
	logic [63:0]       quo_prod, rem_c;
	logic [CNT_W-1:0]  cnt_c;
	logic [63:0]       dens_prod;
	logic [DENS_W-1:0] dens_c;

	axis_tag_t         ax_tag;
	logic [31:0]       ax_point, ax_origin, ax_inv;
	logic [DIM_W-1:0]  ax_dim;
	logic [IDX_W-1:0]  ax_idx;
	axis_stat_t        ax_stat;

	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		case (axis_q)
			AXIS_X: begin
				ax_point = px_q; ax_origin = min_x_q; ax_inv = inv_x_q; ax_dim = dx_q;
			end
			AXIS_Y: begin
				ax_point = py_q; ax_origin = min_y_q; ax_inv = inv_y_q; ax_dim = dy_q;
			end
			default: begin
				ax_point = pz_q; ax_origin = min_z_q; ax_inv = inv_z_q; ax_dim = dz_q;
			end
		endcase
	end

	assign ax_tag = '{valid: state_q == ST_AXIS, axis: axis_q};

	vpdb_axis #(.GRID_MAX(GRID_MAX)) u_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.tag    (ax_tag),
		.point  (ax_point),
		.origin (ax_origin),
		.inv    (ax_inv),
		.dim    (ax_dim),
		.idx    (ax_idx),
		.stat   (ax_stat)
	);

	assign lin_c    = LIN_W'(ix_q) + t1_q + t2_q;
	assign lin_wrap = 32'(lin_c) >= 32'(TABLE_DEPTH);
	assign quo_prod = 64'(lin_q) * RECIP;
	assign rem_c    = 64'(lin_q) - 64'(quo_q) * 64'(TABLE_DEPTH);

	always_comb begin
		if (op_q == OP_ADD)
			cnt_c = (rdata_q == CNT_MAX) ? rdata_q : rdata_q + CNT_W'(1);
		else
			cnt_c = in_range_q ? rdata_q : '0;
	end

	assign dens_prod = 64'(cnt_q) * 64'(inv_vol_q);
	assign dens_c    = (|dens_prod[63:DENS_W]) ? DENS_MAX : dens_prod[DENS_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == LAST_ADR) state_d = ST_IDLE;
			ST_IDLE: begin
				if (s_axis_tvalid)
					state_d = (s_axis_tuser[0] == OP_ADD) ? ST_AXIS : ST_MEM_RD;
			end
			ST_AXIS:   if (axis_q == AXIS_Z) state_d = ST_WAIT;
			ST_WAIT:   if (ax_stat.valid && ax_stat.axis == AXIS_Z) state_d = ST_LIN1;
			ST_LIN1:   state_d = ST_LIN2;
			ST_LIN2:   state_d = lin_wrap ? ST_MOD : ST_MEM_RD;
			ST_MOD:    if (mod_ph_q) state_d = ST_MEM_RD;
			ST_MEM_RD: state_d = ST_MEM_WR;
			ST_MEM_WR: state_d = ST_DENS;
			ST_DENS:   if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_waddr     = addr_q;
		mem_wdata     = '0;
		out_load      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_MEM_RD: mem_re = 1'b1;
			ST_MEM_WR: begin
				mem_we    = in_range_q;
				mem_wdata = (op_q == OP_ADD) ? cnt_c : '0;
			end
			ST_DENS:   out_load = !out_valid_q || m_axis_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			axis_q      <= AXIS_X;
			mod_ph_q    <= 1'b0;
			out_valid_q <= 1'b0;
			min_x_q     <= '0;
			min_y_q     <= '0;
			min_z_q     <= '0;
			inv_x_q     <= 32'd65536;
			inv_y_q     <= 32'd65536;
			inv_z_q     <= 32'd65536;
			dims_q      <= 24'h202020;
			inv_vol_q   <= 32'd65536;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + ADDR_W'(1);
			if (state_q == ST_IDLE) begin
				axis_q <= AXIS_X;
			end else if (state_q == ST_AXIS) begin
				case (axis_q)
					AXIS_X:  axis_q <= AXIS_Y;
					AXIS_Y:  axis_q <= AXIS_Z;
					default: axis_q <= AXIS_X;
				endcase
			end
			if (state_q == ST_MOD)
				mod_ph_q <= !mod_ph_q;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_X:     min_x_q   <= cfg_data;
					CFG_MIN_Y:     min_y_q   <= cfg_data;
					CFG_MIN_Z:     min_z_q   <= cfg_data;
					CFG_INV_X:     inv_x_q   <= cfg_data;
					CFG_INV_Y:     inv_y_q   <= cfg_data;
					CFG_INV_Z:     inv_z_q   <= cfg_data;
					CFG_GRID_DIMS: dims_q    <= cfg_data[23:0];
					CFG_INV_VOL:   inv_vol_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_q  <= dim_of(dims_q[7:0]);
		dy_q  <= dim_of(dims_q[15:8]);
		dz_q  <= dim_of(dims_q[23:16]);
		dxy_q <= DXY_W'(dx_q) * DXY_W'(dy_q);

		if (accept) begin
			op_q       <= s_axis_tuser[0];
			px_q       <= s_axis_tdata[31:0];
			py_q       <= s_axis_tdata[63:32];
			pz_q       <= s_axis_tdata[95:64];
			cidx_q     <= s_axis_tdata[110:96];
			addr_q     <= ADDR_W'(s_axis_tdata[110:96]);
			in_range_q <= (s_axis_tuser[0] == OP_ADD) ||
			              (32'(s_axis_tdata[110:96]) < 32'(TABLE_DEPTH));
			clamp_q    <= 1'b0;
		end else if (ax_stat.valid) begin
			clamp_q <= clamp_q | ax_stat.clamp;
		end

		if (ax_stat.valid) begin
			case (ax_stat.axis)
				AXIS_X:  ix_q <= ax_idx;
				AXIS_Y:  iy_q <= ax_idx;
				default: iz_q <= ax_idx;
			endcase
		end

		if (state_q == ST_LIN1) begin
			t1_q <= LIN_W'(iy_q) * LIN_W'(dx_q);
			t2_q <= LIN_W'(iz_q) * LIN_W'(dxy_q);
		end

		if (state_q == ST_LIN2) begin
			lin_q <= lin_c;
			if (!lin_wrap) begin
				addr_q <= ADDR_W'(lin_c);
				cidx_q <= SEL_W'(lin_c);
			end
		end else if (state_q == ST_MOD) begin
			if (!mod_ph_q) begin
				quo_q <= LIN_W'(quo_prod >> MOD_SH);
			end else begin
				addr_q <= ADDR_W'(rem_c);
				cidx_q <= SEL_W'(rem_c);
			end
		end

		if (state_q == ST_MEM_WR)
			cnt_q <= cnt_c;

		if (out_load) begin
			out_kind_q  <= (op_q == OP_ADD) ? KIND_ADD : KIND_READ;
			out_cidx_q  <= cidx_q;
			out_cnt_q   <= cnt_q;
			out_dens_q  <= dens_c;
			out_clamp_q <= clamp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			count_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= count_mem[addr_q];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {out_clamp_q, out_dens_q, out_cnt_q, out_cidx_q};

endmodule
